### rtl/hvt_pkg.sv
// Shared types and constants for the homogeneous vertex transform.
// No dependencies.
`default_nettype none
package hvt_pkg;
  localparam int CFG_IW  = 8;
  localparam int CFG_DW  = 64;
  localparam int NUM_REG = 8;
  localparam int HW      = 66;   // exact Q32.32 dot-product width
  localparam int NW      = 82;   // numerator scaled by 2^16
  localparam int CW      = 98;   // compare width for den << 32
  localparam int QBITS   = 32;
  localparam int QDEPTH  = 4;
  localparam int QAW     = 2;
  localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;

  typedef struct packed {
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               w_zero;
  } out_word_t;

  // one classified vertex: magnitudes, quotient signs, divisor, zero flag
  typedef struct packed {
    logic [2:0][HW-1:0] num;
    logic [2:0]         neg;
    logic [HW-1:0]      den;
    logic               wz;
  } job_t;
endpackage
`default_nettype wire

### rtl/hvt_front.sv
// Front end: matrix registers, 16 multiplies, row sums and sign/zero classify.
// Depends on hvt_pkg.
`default_nettype none
module hvt_front (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       cfg_we,
  input  wire [hvt_pkg::CFG_IW-1:0] cfg_index,
  input  wire [hvt_pkg::CFG_DW-1:0] cfg_data,
  input  wire                       in_valid,
  output logic                      in_ready,
  input  hvt_pkg::in_word_t         in_data,
  output logic                      job_valid,
  input  wire                       job_ready,
  output hvt_pkg::job_t             job
);
  logic [hvt_pkg::CFG_DW-1:0] regs [hvt_pkg::NUM_REG];
  logic signed [31:0] m [4][4];
  logic signed [31:0] vv [4];
  logic signed [63:0] prod [4][4];
  logic signed [hvt_pkg::HW-1:0] h [4];
  logic v1, v2, en;
  hvt_pkg::job_t job_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs[0] <= 64'd65536;
      regs[1] <= 64'd0;
      regs[2] <= 64'd281474976710656;
      regs[3] <= 64'd0;
      regs[4] <= 64'd0;
      regs[5] <= 64'd65536;
      regs[6] <= 64'd0;
      regs[7] <= 64'd281474976710656;
    end else if (cfg_we && cfg_index < hvt_pkg::CFG_IW'(hvt_pkg::NUM_REG)) begin
      regs[cfg_index[2:0]] <= cfg_data;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        m[i][j] = regs[i*2 + j/2][(j%2)*32 +: 32];
    vv[0] = in_data.in_x;
    vv[1] = in_data.in_y;
    vv[2] = in_data.in_z;
    vv[3] = 32'sd65536;
  end

  assign en       = !v2 || job_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++)
        for (int j = 0; j < 4; j++)
          prod[i][j] <= m[i][j] * vv[j];
      job <= job_next;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++)
      h[i] = {{2{prod[i][0][63]}}, prod[i][0]} + {{2{prod[i][1][63]}}, prod[i][1]}
           + {{2{prod[i][2][63]}}, prod[i][2]} + {{2{prod[i][3][63]}}, prod[i][3]};
    for (int i = 0; i < 3; i++) begin
      job_next.num[i] = h[i][hvt_pkg::HW-1] ? -h[i] : h[i];
      job_next.neg[i] = h[i][hvt_pkg::HW-1] ^ h[3][hvt_pkg::HW-1];
    end
    job_next.den = h[3][hvt_pkg::HW-1] ? -h[3] : h[3];
    job_next.wz  = (h[3] == '0);
  end

  assign job_valid = v2;
endmodule
`default_nettype wire

### rtl/hvt_queue.sv
// Short FIFO of classified jobs between front and back ends.
// Depends on hvt_pkg.
`default_nettype none
module hvt_queue (
  input  wire           clk,
  input  wire           rst,
  input  wire           push,
  output logic          push_ready,
  input  hvt_pkg::job_t push_data,
  input  wire           pop,
  output logic          pop_valid,
  output hvt_pkg::job_t pop_data
);
  hvt_pkg::job_t mem [hvt_pkg::QDEPTH];
  logic [hvt_pkg::QAW-1:0] wr_ptr, rd_ptr;
  logic [hvt_pkg::QAW:0]   count;
  logic do_push, do_pop;

  assign push_ready = (count != (hvt_pkg::QAW+1)'(hvt_pkg::QDEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (hvt_pkg::QAW+1)'(do_push) - (hvt_pkg::QAW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end
endmodule
`default_nettype wire

### rtl/hvt_back.sv
// Back end: three pipelined restoring dividers, one quotient bit per stage after the
// entry stage, then saturation into the output register. Depends on hvt_pkg.
`default_nettype none
module hvt_back (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 job_valid,
  output logic                job_pop,
  input  hvt_pkg::job_t       job,
  output logic                out_valid,
  input  wire                 out_ready,
  output hvt_pkg::out_word_t  out_data
);
  localparam int NS = hvt_pkg::QBITS + 1;
  logic [hvt_pkg::NW-1:0]    rem [NS][3];
  logic [hvt_pkg::QBITS-1:0] q   [NS][3];
  logic [2:0]                ov  [NS];
  logic [2:0]                neg [NS];
  logic [hvt_pkg::HW-1:0]    den [NS];
  logic                      wz  [NS];
  logic                      vld [NS];
  logic en;
  logic [31:0] res [3];

  assign en      = !out_valid || out_ready;
  assign job_pop = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NS; s++) vld[s] <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld[0] <= job_valid;
      for (int s = 1; s < NS; s++) vld[s] <= vld[s-1];
      out_valid <= vld[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // entry stage: scale numerator and flag quotients of 2^32 or more
      for (int l = 0; l < 3; l++) begin
        rem[0][l] <= {job.num[l], 16'b0};
        q[0][l]   <= '0;
        ov[0][l]  <= {16'b0, job.num[l], 16'b0} >=
                     ({32'b0, job.den} << hvt_pkg::QBITS);
      end
      neg[0] <= job.neg;
      den[0] <= job.den;
      wz[0]  <= job.wz;
      for (int s = 1; s < NS; s++) begin
        for (int l = 0; l < 3; l++) begin
          if ({16'b0, rem[s-1][l]} >= ({32'b0, den[s-1]} << (NS-1-s))) begin
            rem[s][l] <= hvt_pkg::NW'({16'b0, rem[s-1][l]}
                         - ({32'b0, den[s-1]} << (NS-1-s)));
            q[s][l]   <= q[s-1][l] | (32'd1 << (NS-1-s));
          end else begin
            rem[s][l] <= rem[s-1][l];
            q[s][l]   <= q[s-1][l];
          end
        end
        ov[s]  <= ov[s-1];
        neg[s] <= neg[s-1];
        den[s] <= den[s-1];
        wz[s]  <= wz[s-1];
      end
      out_data.out_x  <= res[0];
      out_data.out_y  <= res[1];
      out_data.out_z  <= res[2];
      out_data.w_zero <= wz[NS-1];
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (wz[NS-1])
        res[l] = hvt_pkg::SAT_POS;
      else if (!neg[NS-1][l])
        res[l] = (ov[NS-1][l] || q[NS-1][l] > hvt_pkg::SAT_POS) ? hvt_pkg::SAT_POS
                                                               : q[NS-1][l];
      else
        res[l] = (ov[NS-1][l] || q[NS-1][l] > hvt_pkg::SAT_NEG) ? hvt_pkg::SAT_NEG
                                                               : 32'd0 - q[NS-1][l];
    end
  end
endmodule
`default_nettype wire

### rtl/homogeneous_vertex_transform_core.sv
// Homogeneous 4x4 vertex transform with perspective divide, Q16.16.
// Throughput: one vertex word per cycle while output words are taken; from the
// accept edge to out_valid with an empty queue a word passes the second front
// stage, the queue write, 33 divider stages and the output register.
// The divider pipeline (one quotient bit per stage after the entry stage) sets the latency.
// Reset (rst, synchronous): matrix returns to identity, pipeline and queue
// empty. Config writes are taken at any cycle.
`default_nettype none
module homogeneous_vertex_transform_core (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       cfg_we,
  input  wire [hvt_pkg::CFG_IW-1:0] cfg_index,
  input  wire [hvt_pkg::CFG_DW-1:0] cfg_data,
  input  wire                       in_valid,
  output logic                      in_ready,
  input  hvt_pkg::in_word_t         in_data,
  output logic                      out_valid,
  input  wire                       out_ready,
  output hvt_pkg::out_word_t        out_data
);
  // front -> queue
  logic          f_valid, f_ready;
  hvt_pkg::job_t f_job;
  // queue -> back
  logic          b_valid, b_pop;
  hvt_pkg::job_t b_job;

  // multiply and sum; stalls only when the queue is full
  hvt_front u_front (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
  );

  // decouples front stalls from the divider stalls
  hvt_queue u_queue (
    .clk(clk), .rst(rst),
    .push(f_valid), .push_ready(f_ready), .push_data(f_job),
    .pop(b_pop), .pop_valid(b_valid), .pop_data(b_job)
  );

  // divide, saturate, hold result word until taken
  hvt_back u_back (
    .clk(clk), .rst(rst),
    .job_valid(b_valid), .job_pop(b_pop), .job(b_job),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );
endmodule
`default_nettype wire
